[rtl/lds_pkg.sv]
// Shared constants, types and the segment table of the LED driver serial transmitter.
package lds_pkg;

   // Default number of digits sent by one burst command
   localparam int DIGITS_PER_BURST_DEF = 8;
   // Number of digit fields carried by one request
   localparam int NUM_DIGIT_FIELDS = 8;
   // Entries of the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // Request operation codes
   localparam logic [2:0] OP_TICK  = 3'd0;
   localparam logic [2:0] OP_SETUP = 3'd1;
   localparam logic [2:0] OP_DIGIT = 3'd2;
   localparam logic [2:0] OP_BURST = 3'd3;
   localparam logic [2:0] OP_RAW   = 3'd4;

   // Configuration register indexes
   localparam logic [1:0] CSR_MODE_BYTE       = 2'd0;
   localparam logic [1:0] CSR_DISPLAY_CONTROL = 2'd1;
   localparam logic [1:0] CSR_LED_ADDRESS     = 2'd2;
   localparam logic [1:0] CSR_PHASE_TICKS     = 2'd3;

   // Configuration reset values
   localparam logic [7:0] MODE_BYTE_RST       = 8'h40;
   localparam logic [7:0] DISPLAY_CONTROL_RST = 8'h8c;
   localparam logic [7:0] LED_ADDRESS_RST     = 8'hc0;
   localparam logic [7:0] PHASE_TICKS_RST     = 8'h01;

   // Base of the grid address command
   localparam logic [7:0] GRID_ADDR_BASE = 8'hc0;

   // Item classes passed from front to back
   localparam logic [1:0] KIND_NONE = 2'd0;
   localparam logic [1:0] KIND_TICK = 2'd1;
   localparam logic [1:0] KIND_CMD  = 2'd2;

   // Classification that travels with each queued item
   typedef struct packed {
      logic [1:0] kind;
      logic       second;
   } lds_ctrl_type;

   // Segment patterns: plain digits, digits with decimal point, blank
   localparam int SEG_ENTRIES = 21;
   localparam logic [7:0] SEG_TABLE [SEG_ENTRIES] = '{
      8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h6f,
      8'hbf, 8'h86, 8'hdb, 8'hcf, 8'he6, 8'hed, 8'hfd, 8'h87, 8'hff, 8'hef,
      8'h00
   };

   // Map a digit code to its segment pattern; codes past the table are blank
   function automatic logic [7:0] seg_of(input logic [4:0] code);
      logic [7:0] pattern;
      pattern = 8'h00;
      if (code < 5'(SEG_ENTRIES)) begin
         pattern = SEG_TABLE[code];
      end
      return pattern;
   endfunction

endpackage

[rtl/lds_if.sv]
// Valid/ready channel interfaces for request, response and register write transfers.
interface lds_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] op;
   logic [3:0] address;
   logic [7:0] raw_byte;
   logic [4:0] digit0;
   logic [4:0] digit1;
   logic [4:0] digit2;
   logic [4:0] digit3;
   logic [4:0] digit4;
   logic [4:0] digit5;
   logic [4:0] digit6;
   logic [4:0] digit7;

   modport source (
      output valid, op, address, raw_byte,
      output digit0, digit1, digit2, digit3, digit4, digit5, digit6, digit7,
      input  ready
   );
   modport sink (
      input  valid, op, address, raw_byte,
      input  digit0, digit1, digit2, digit3, digit4, digit5, digit6, digit7,
      output ready
   );
endinterface

interface lds_rsp_if;
   logic valid;
   logic ready;
   logic clock_pin;
   logic data_pin;
   logic busy_res;
   logic sequence_done;
   logic rejected;

   modport source (
      output valid, clock_pin, data_pin, busy_res, sequence_done, rejected,
      input  ready
   );
   modport sink (
      input  valid, clock_pin, data_pin, busy_res, sequence_done, rejected,
      output ready
   );
endinterface

interface lds_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] index;
   logic [7:0] data;

   modport source (
      output valid, index, data,
      input  ready
   );
   modport sink (
      input  valid, index, data,
      output ready
   );
endinterface

[rtl/lds_front.sv]
// Front end: accepts requests, classifies them and builds the frame bytes.
module lds_front #(
   parameter int DIGITS_PER_BURST = lds_pkg::DIGITS_PER_BURST_DEF,
   parameter int STORE_DEPTH      = DIGITS_PER_BURST + 2,
   parameter int POS_W            = $clog2(STORE_DEPTH)
) (
   lds_req_if.sink                        req,
   input  logic                           queue_full,
   input  logic [7:0]                     mode_byte,
   input  logic [7:0]                     display_control,
   input  logic [7:0]                     led_address,
   output logic                           push,
   output lds_pkg::lds_ctrl_type          ctrl,
   output logic [POS_W-1:0]               frame_length,
   output logic [STORE_DEPTH-1:0][7:0]    frame_bytes
);
   import lds_pkg::*;

   logic [4:0] digit_arr [NUM_DIGIT_FIELDS];
   logic [7:0] grid_addr;

   // Accept whenever the queue has room
   assign req.ready = !queue_full;
   assign push      = req.valid && !queue_full;

   assign digit_arr[0] = req.digit0;
   assign digit_arr[1] = req.digit1;
   assign digit_arr[2] = req.digit2;
   assign digit_arr[3] = req.digit3;
   assign digit_arr[4] = req.digit4;
   assign digit_arr[5] = req.digit5;
   assign digit_arr[6] = req.digit6;
   assign digit_arr[7] = req.digit7;

   assign grid_addr = GRID_ADDR_BASE + {4'h0, req.address};

   // Classify the op and fill the frame bytes
   always_comb begin
      ctrl         = '{kind: KIND_NONE, second: 1'b0};
      frame_length = '0;
      frame_bytes  = '0;
      case (req.op)
         OP_TICK: begin
            ctrl.kind = KIND_TICK;
         end
         OP_SETUP: begin
            ctrl.kind      = KIND_CMD;
            ctrl.second    = 1'b1;
            frame_bytes[0] = mode_byte;
            frame_bytes[1] = display_control;
            frame_length   = POS_W'(1);
         end
         OP_DIGIT: begin
            ctrl.kind      = KIND_CMD;
            frame_bytes[0] = grid_addr;
            frame_bytes[1] = seg_of(req.digit0);
            frame_length   = POS_W'(2);
         end
         OP_BURST: begin
            ctrl.kind      = KIND_CMD;
            frame_bytes[0] = grid_addr;
            // digits past the last digit field go out blank
            for (int i = 0; i < DIGITS_PER_BURST; i++) begin
               frame_bytes[i+1] = (i < NUM_DIGIT_FIELDS) ?
                                  seg_of(digit_arr[i % NUM_DIGIT_FIELDS]) : 8'h00;
            end
            frame_length = POS_W'(DIGITS_PER_BURST + 1);
         end
         OP_RAW: begin
            ctrl.kind      = KIND_CMD;
            frame_bytes[0] = led_address;
            frame_bytes[1] = req.raw_byte;
            frame_length   = POS_W'(2);
         end
         default: begin
            ctrl.kind = KIND_NONE;
         end
      endcase
   end

endmodule

[rtl/lds_queue.sv]
// Small first-in first-out queue between the front end and the pin sequencer.
module lds_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = lds_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic             full,
   output logic             not_empty,
   output logic [WIDTH-1:0] pop_data
);
   import lds_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   // Advance pointers with wrap and track the fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed entry
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[rtl/lds_back.sv]
// Back end: runs the pin phase sequencer and registers each response.
module lds_back #(
   parameter int STORE_DEPTH = lds_pkg::DIGITS_PER_BURST_DEF + 2,
   parameter int POS_W       = $clog2(STORE_DEPTH)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          item_valid,
   input  lds_pkg::lds_ctrl_type         item_ctrl,
   input  logic [POS_W-1:0]              item_length,
   input  logic [STORE_DEPTH-1:0][7:0]   item_bytes,
   input  logic [7:0]                    phase_ticks,
   output logic                          pop,
   lds_rsp_if.source                     rsp
);
   import lds_pkg::*;

   // Pin phase codes
   localparam logic [3:0] PH_IDLE      = 4'd0;
   localparam logic [3:0] PH_ST_HIGH   = 4'd1;
   localparam logic [3:0] PH_ST_DLOW   = 4'd2;
   localparam logic [3:0] PH_ST_CLOW   = 4'd3;
   localparam logic [3:0] PH_BIT_CLOW  = 4'd4;
   localparam logic [3:0] PH_BIT_DATA  = 4'd5;
   localparam logic [3:0] PH_BIT_CHIGH = 4'd6;
   localparam logic [3:0] PH_BYTE_END  = 4'd7;
   localparam logic [3:0] PH_SP_CHIGH  = 4'd8;
   localparam logic [3:0] PH_SP_DHIGH  = 4'd9;

   logic [STORE_DEPTH-1:0][7:0] store_ff;
   logic [3:0]       phase_ff, phase_in;
   logic [7:0]       hold_ff, hold_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [2:0]       bit_ff, bit_in;
   logic [POS_W-1:0] len_ff, len_in;
   logic             second_ff, second_in;
   logic             clk_lvl_ff, clk_lvl_in;
   logic             dat_lvl_ff, dat_lvl_in;
   logic             rsp_valid_ff;
   logic             clock_pin_ff, data_pin_ff, busy_ff, done_ff, rej_ff;
   logic             done_in, rej_in;
   logic             load_frame, restart_frame;
   logic             busy;
   logic             advance;
   logic [7:0]       cur_byte;
   logic [7:0]       limit;
   logic [8:0]       hold_next;

   assign busy    = (phase_ff != PH_IDLE);
   assign advance = item_valid && (!rsp_valid_ff || rsp.ready);
   assign pop     = advance;
   assign limit   = (phase_ticks == 8'd0) ? 8'd1 : phase_ticks;
   assign hold_next = {1'b0, hold_ff} + 9'd1;
   assign cur_byte  = ({1'b0, pos_ff} < (POS_W+1)'(STORE_DEPTH)) ? store_ff[pos_ff] : 8'h00;

   // Work out the next sequencer state for the item at the queue head
   always_comb begin
      phase_in      = phase_ff;
      hold_in       = hold_ff;
      pos_in        = pos_ff;
      bit_in        = bit_ff;
      len_in        = len_ff;
      second_in     = second_ff;
      clk_lvl_in    = clk_lvl_ff;
      dat_lvl_in    = dat_lvl_ff;
      done_in       = 1'b0;
      rej_in        = 1'b0;
      load_frame    = 1'b0;
      restart_frame = 1'b0;
      if (item_ctrl.kind == KIND_CMD) begin
         if (busy) begin
            rej_in = 1'b1;
         end else begin
            load_frame = 1'b1;
            len_in     = item_length;
            second_in  = item_ctrl.second;
            phase_in   = PH_ST_HIGH;
            hold_in    = 8'd0;
            pos_in     = '0;
            bit_in     = 3'd0;
         end
      end else if (item_ctrl.kind == KIND_TICK && busy) begin
         if (hold_next >= {1'b0, limit}) begin
            hold_in = 8'd0;
            case (phase_ff)
               PH_ST_HIGH: begin
                  dat_lvl_in = 1'b1;
                  clk_lvl_in = 1'b1;
                  phase_in   = PH_ST_DLOW;
               end
               PH_ST_DLOW: begin
                  dat_lvl_in = 1'b0;
                  phase_in   = PH_ST_CLOW;
               end
               PH_ST_CLOW: begin
                  clk_lvl_in = 1'b0;
                  pos_in     = '0;
                  bit_in     = 3'd0;
                  phase_in   = PH_BIT_CLOW;
               end
               PH_BIT_CLOW: begin
                  clk_lvl_in = 1'b0;
                  phase_in   = PH_BIT_DATA;
               end
               PH_BIT_DATA: begin
                  dat_lvl_in = cur_byte[bit_ff];
                  phase_in   = PH_BIT_CHIGH;
               end
               PH_BIT_CHIGH: begin
                  clk_lvl_in = 1'b1;
                  if (bit_ff == 3'd7) begin
                     phase_in = PH_BYTE_END;
                  end else begin
                     bit_in   = bit_ff + 3'd1;
                     phase_in = PH_BIT_CLOW;
                  end
               end
               PH_BYTE_END: begin
                  dat_lvl_in = 1'b0;
                  clk_lvl_in = 1'b0;
                  pos_in     = pos_ff + 1'b1;
                  bit_in     = 3'd0;
                  phase_in   = ((pos_ff + 1'b1) < len_ff) ? PH_BIT_CLOW : PH_SP_CHIGH;
               end
               PH_SP_CHIGH: begin
                  dat_lvl_in = 1'b0;
                  clk_lvl_in = 1'b1;
                  phase_in   = PH_SP_DHIGH;
               end
               PH_SP_DHIGH: begin
                  dat_lvl_in = 1'b1;
                  if (second_ff) begin
                     // chain the second setup frame from entry one
                     restart_frame = 1'b1;
                     second_in     = 1'b0;
                     len_in        = POS_W'(1);
                     phase_in      = PH_ST_HIGH;
                     pos_in        = '0;
                     bit_in        = 3'd0;
                  end else begin
                     phase_in = PH_IDLE;
                     done_in  = 1'b1;
                  end
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end else begin
            hold_in = hold_next[7:0];
         end
      end
   end

   // Update sequencer state on each transfer out of the queue
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         hold_ff    <= 8'd0;
         pos_ff     <= '0;
         bit_ff     <= 3'd0;
         len_ff     <= '0;
         second_ff  <= 1'b0;
         clk_lvl_ff <= 1'b1;
         dat_lvl_ff <= 1'b1;
      end else if (advance) begin
         phase_ff   <= phase_in;
         hold_ff    <= hold_in;
         pos_ff     <= pos_in;
         bit_ff     <= bit_in;
         len_ff     <= len_in;
         second_ff  <= second_in;
         clk_lvl_ff <= clk_lvl_in;
         dat_lvl_ff <= dat_lvl_in;
      end
   end

   // Capture frame bytes, or move entry one down for the second frame
   always_ff @(posedge clock) begin
      if (advance && load_frame) begin
         store_ff <= item_bytes;
      end else if (advance && restart_frame) begin
         store_ff[0] <= store_ff[1];
      end
   end

   // Hold the response until the sink takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         clock_pin_ff <= clk_lvl_in;
         data_pin_ff  <= dat_lvl_in;
         busy_ff      <= (phase_in != PH_IDLE);
         done_ff      <= done_in;
         rej_ff       <= rej_in;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.clock_pin     = clock_pin_ff;
   assign rsp.data_pin      = data_pin_ff;
   assign rsp.busy_res      = busy_ff;
   assign rsp.sequence_done = done_ff;
   assign rsp.rejected      = rej_ff;

`ifndef SYNTHESIS
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && done_ff |-> !busy_ff && !rej_ff)
      else $error("sequence end reported while still busy or rejecting");

   a_pos_in_frame: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_BIT_CLOW || phase_ff == PH_BIT_DATA ||
       phase_ff == PH_BIT_CHIGH || phase_ff == PH_BYTE_END) |-> pos_ff < len_ff)
      else $error("byte position ran past the frame length");

   a_data_under_low_clock: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_BIT_CHIGH |-> !clk_lvl_ff)
      else $error("data changed while the serial clock was high");

   a_second_single_byte: assert property (@(posedge clock) disable iff (reset)
      second_ff |-> len_ff == POS_W'(1))
      else $error("second setup frame pending with a multi-byte frame");
`endif

endmodule

[rtl/led_driver_serial_transmitter.sv]
// Top level of the LED driver serial transmitter: registers, front end, queue and sequencer.
//
//   channel  | direction | transfer carries
//   ---------+-----------+-------------------------------------------------------
//   req_bus  | in        | op, address, raw_byte, digit0..digit7
//   rsp_bus  | out       | clock_pin, data_pin, busy_res, sequence_done, rejected
//   csr_bus  | in        | index, data (register write, always ready)
//
// One request per clock cycle sustained while responses are taken.
// The back end pin sequencer handles one queued item per cycle while responses are taken.
// Synchronous reset: pins high, sequencer idle, registers at their defaults.
// A stalled response holds its register; the two-entry queue then fills and drops req ready.
module led_driver_serial_transmitter #(
   parameter int DIGITS_PER_BURST = lds_pkg::DIGITS_PER_BURST_DEF
) (
   input  logic      clock,
   input  logic      reset,
   lds_req_if.sink   req_bus,
   lds_rsp_if.source rsp_bus,
   lds_csr_if.sink   csr_bus
);
   import lds_pkg::*;

   localparam int STORE_DEPTH = DIGITS_PER_BURST + 2;
   localparam int POS_W       = $clog2(STORE_DEPTH);
   localparam int ENTRY_W     = $bits(lds_ctrl_type) + POS_W + 8 * STORE_DEPTH;

   logic [7:0] mode_byte_ff;
   logic [7:0] display_control_ff;
   logic [7:0] led_address_ff;
   logic [7:0] phase_ticks_ff;

   logic                        push;
   logic                        pop;
   logic                        queue_full;
   logic                        queue_valid;
   lds_ctrl_type                front_ctrl;
   logic [POS_W-1:0]            front_length;
   logic [STORE_DEPTH-1:0][7:0] front_bytes;
   logic [ENTRY_W-1:0]          push_data;
   logic [ENTRY_W-1:0]          pop_data;
   lds_ctrl_type                back_ctrl;
   logic [POS_W-1:0]            back_length;
   logic [STORE_DEPTH-1:0][7:0] back_bytes;

   // Take register writes at any time
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_byte_ff       <= MODE_BYTE_RST;
         display_control_ff <= DISPLAY_CONTROL_RST;
         led_address_ff     <= LED_ADDRESS_RST;
         phase_ticks_ff     <= PHASE_TICKS_RST;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_MODE_BYTE:       mode_byte_ff       <= csr_bus.data;
            CSR_DISPLAY_CONTROL: display_control_ff <= csr_bus.data;
            CSR_LED_ADDRESS:     led_address_ff     <= csr_bus.data;
            CSR_PHASE_TICKS:     phase_ticks_ff     <= csr_bus.data;
            default: begin
            end
         endcase
      end
   end

   lds_front #(
      .DIGITS_PER_BURST (DIGITS_PER_BURST),
      .STORE_DEPTH      (STORE_DEPTH),
      .POS_W            (POS_W)
   ) u_front (
      .req             (req_bus),
      .queue_full      (queue_full),
      .mode_byte       (mode_byte_ff),
      .display_control (display_control_ff),
      .led_address     (led_address_ff),
      .push            (push),
      .ctrl            (front_ctrl),
      .frame_length    (front_length),
      .frame_bytes     (front_bytes)
   );

   // Pack and unpack queue entries
   assign push_data = {front_ctrl, front_length, front_bytes};
   assign {back_ctrl, back_length, back_bytes} = pop_data;

   lds_queue #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .full      (queue_full),
      .not_empty (queue_valid),
      .pop_data  (pop_data)
   );

   lds_back #(
      .STORE_DEPTH (STORE_DEPTH),
      .POS_W       (POS_W)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (queue_valid),
      .item_ctrl   (back_ctrl),
      .item_length (back_length),
      .item_bytes  (back_bytes),
      .phase_ticks (phase_ticks_ff),
      .pop         (pop),
      .rsp         (rsp_bus)
   );

endmodule
